// ===== rtl/core/slf_pkg.sv =====
// slf_pkg: shared widths, defaults, status codes and table entry type
// for the single-slice label finder; no dependencies
package slf_pkg;

    localparam int SLF_LABEL_W = 16;
    localparam int SLF_SLICE_W = 10;
    localparam int SLF_COUNT_W = 17;
    localparam int SLF_ENTRY_W = 12;

    // labels the 16-bit label field can name
    localparam int SLF_LABEL_SPAN = 65536;

    localparam int SLF_LABELS_DEF = 65536;
    localparam int SLF_SLICES_DEF = 1024;

    localparam logic [SLF_COUNT_W-1:0] SLF_COUNT_MAX = '1;

    typedef logic [1:0] slf_code_t;

    localparam slf_code_t SLF_CODE_UNSEEN = 2'd0;
    localparam slf_code_t SLF_CODE_SINGLE = 2'd1;
    localparam slf_code_t SLF_CODE_MULTI  = 2'd2;

    typedef struct packed {
        slf_code_t                code;
        logic [SLF_SLICE_W-1:0]   slice;
    } slf_entry_t;

endpackage

// ===== rtl/core/slf_ifs.sv =====
// slf_ifs: valid/ready channels for voxel words and result words
// depends on slf_pkg
interface slf_vox_if import slf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [SLF_LABEL_W-1:0] label;
    logic [SLF_SLICE_W-1:0] slice;
    logic                   last_voxel;

    modport source (output valid, output label, output slice, output last_voxel, input ready);
    modport sink   (input valid, input label, input slice, input last_voxel, output ready);
endinterface

interface slf_res_if import slf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [SLF_COUNT_W-1:0] singleton_count;
    logic                   final_res;

    modport source (output valid, output singleton_count, output final_res, input ready);
    modport sink   (input valid, input singleton_count, input final_res, output ready);
endinterface

// ===== rtl/core/slf_ram.sv =====
// slf_ram: generic single-write, single-read ram with registered read
// no dependencies
module slf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/slf_clear.sv =====
// slf_clear: post-reset sweep that walks every table address once
// no dependencies
module slf_clear #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     busy,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg)
        begin
            addr_next = addr_reg + ADDR_W'(1);
            if (addr_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign busy = busy_reg;
    assign addr = addr_reg;

endmodule

// ===== rtl/core/single_slice_label_finder.sv =====
// single_slice_label_finder: counts labels seen in exactly one z slice
// an accepted voxel word is registered in the s1 stage, then in the result register as its result word
// throughput: one voxel word per cycle while the result channel does not stall; the status table
//   read is registered, and its read-modify-write hazard is covered by forwarding the last write
// reset: table cleared by a sweep over min(LABELS, 65536) addresses, no voxel taken meanwhile
// depends on slf_pkg, slf_ifs, slf_ram, slf_clear
module single_slice_label_finder import slf_pkg::*; #(
    parameter int LABELS = SLF_LABELS_DEF,
    parameter int SLICES = SLF_SLICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    slf_vox_if.sink    vox,
    slf_res_if.source  res
);

    localparam int DEPTH  = (LABELS > SLF_LABEL_SPAN) ? SLF_LABEL_SPAN : LABELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [24:0] LABELS_L = 25'(LABELS);
    localparam logic [16:0] SLICES_L = 17'(SLICES);

    logic              clr_busy;
    logic [ADDR_W-1:0] clr_addr;

    logic                   vox_take;
    logic                   vox_hit;
    logic [ADDR_W-1:0]      vox_addr;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_hit_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic [SLF_SLICE_W-1:0] s1_slice_reg;
    logic                   s1_last_reg;

    logic                   fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]      fwd_addr_reg;
    slf_entry_t             fwd_data_reg;

    logic [SLF_COUNT_W-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SLF_COUNT_W-1:0] out_count_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   s1_move;
    logic                   s1_go;
    logic [SLF_ENTRY_W-1:0] ram_rdata;
    slf_entry_t             cur;
    slf_entry_t             upd;
    logic                   inc;
    logic                   dec;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    slf_entry_t             ram_wdata;

    slf_clear #(
        .DEPTH (DEPTH)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    slf_ram #(
        .WIDTH (SLF_ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (vox_take),
        .raddr (vox_addr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign s1_move   = !s1_valid_reg || out_free;
    assign s1_go     = s1_valid_reg && out_free;
    assign vox.ready = !clr_busy && s1_move;
    assign vox_take  = vox.valid && vox.ready;
    assign vox_addr  = vox.label[ADDR_W-1:0];
    assign vox_hit   = ({9'b0, vox.label} < LABELS_L) && ({7'b0, vox.slice} < SLICES_L);

    // forward the write that lands on the same edge as this word's read
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur = fwd_data_reg;
        end
        else
        begin
            cur = slf_entry_t'(ram_rdata);
        end
        upd = cur;
        inc = 1'b0;
        dec = 1'b0;
        unique case (cur.code)
            SLF_CODE_UNSEEN:
            begin
                upd.code  = SLF_CODE_SINGLE;
                upd.slice = s1_slice_reg;
                inc       = 1'b1;
            end
            SLF_CODE_SINGLE:
            begin
                if (cur.slice != s1_slice_reg)
                begin
                    upd.code  = SLF_CODE_MULTI;
                    upd.slice = '0;
                    dec       = 1'b1;
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (s1_go && s1_hit_reg)
        begin
            if (inc && (count_reg != SLF_COUNT_MAX))
            begin
                count_next = count_reg + SLF_COUNT_W'(1);
            end
            else if (dec && (count_reg != '0))
            begin
                count_next = count_reg - SLF_COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (clr_busy)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = '{code: SLF_CODE_UNSEEN, slice: '0};
        end
        else
        begin
            ram_we    = s1_go && s1_hit_reg;
            ram_waddr = s1_addr_reg;
            ram_wdata = upd;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        if (s1_move)
        begin
            s1_valid_next  = vox_take;
            fwd_valid_next = s1_go && s1_hit_reg;
        end
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vox_take)
        begin
            s1_hit_reg   <= vox_hit;
            s1_addr_reg  <= vox_addr;
            s1_slice_reg <= vox.slice;
            s1_last_reg  <= vox.last_voxel;
        end
        if (s1_move)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= upd;
        end
        if (s1_go)
        begin
            out_count_reg <= count_next;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.singleton_count = out_count_reg;
    assign res.final_res       = out_last_reg;

endmodule

// ===== rtl/core/slf_checker.sv =====
// slf_checker: port-level assertions for single_slice_label_finder
// depends on slf_pkg; bound to the top level below
module slf_checker import slf_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SLF_COUNT_W-1:0] out_count,
    input logic                   out_final
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_final))
        else $error("result word changed while stalled");

    // consecutive result words differ by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) ##1 out_valid |->
            (out_count == $past(out_count)) ||
            (out_count == $past(out_count) + SLF_COUNT_W'(1)) ||
            (out_count == $past(out_count) - SLF_COUNT_W'(1)))
        else $error("count moved by more than one");

    // a rising result valid must trace back to an accepted voxel word
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a voxel word");

    // at most one count per distinct label
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count <= SLF_COUNT_W'(SLF_LABEL_SPAN))
        else $error("count above label span");

endmodule

bind single_slice_label_finder slf_checker u_slf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vox.valid),
    .in_ready  (vox.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_count (res.singleton_count),
    .out_final (res.final_res)
);
